// ===== rtl/h4ftq_pkg.sv =====
// ----------------------------------------------------------------------------
// h4ftq_pkg
// Shared types and constants for the 4x4 forward transform and quantizer.
// ----------------------------------------------------------------------------
package h4ftq_pkg;

   localparam int COEFF_BITS = 13;
   localparam int QP_BITS    = 6;
   localparam int QP_MAX     = 51;
   localparam int MF_BITS    = 14;
   localparam int QBITS_MIN  = 15;

   localparam logic CSR_QP    = 1'b0;
   localparam logic CSR_INTER = 1'b1;

   // multiplier row for qp % 6, by position class
   function automatic logic [MF_BITS-1:0] mf_lookup(input logic [2:0] rem,
                                                    input logic [1:0] cls);
      logic [MF_BITS-1:0] v;
      begin
         v = '0;
         unique case (rem)
            3'd0: v = (cls == 2'd0) ? 14'd13107 : (cls == 2'd1) ? 14'd5243 : 14'd8066;
            3'd1: v = (cls == 2'd0) ? 14'd11916 : (cls == 2'd1) ? 14'd4660 : 14'd7490;
            3'd2: v = (cls == 2'd0) ? 14'd10082 : (cls == 2'd1) ? 14'd4194 : 14'd6554;
            3'd3: v = (cls == 2'd0) ? 14'd9362  : (cls == 2'd1) ? 14'd3647 : 14'd5825;
            3'd4: v = (cls == 2'd0) ? 14'd8192  : (cls == 2'd1) ? 14'd3355 : 14'd5243;
            3'd5: v = (cls == 2'd0) ? 14'd7282  : (cls == 2'd1) ? 14'd2893 : 14'd4559;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   // qp split into period and remainder, period by reciprocal multiply
   function automatic logic [6:0] qp_split(input logic [QP_BITS-1:0] qp);
      logic [5:0]  q;
      logic [11:0] recip;
      logic [3:0]  per;
      logic [2:0]  rem;
      begin
         q     = (qp > 6'(QP_MAX)) ? 6'(QP_MAX) : qp;
         // q * 43 / 256 equals q / 6 for q up to 51
         recip = 12'(q) * 12'd43;
         per   = recip[11:8];
         rem   = 3'(q - 6'(per) * 6'd6);
         return {per, rem};
      end
   endfunction

endpackage

// ===== rtl/h4ftq_front.sv =====
// ----------------------------------------------------------------------------
// h4ftq_front
// Collects four rows, then runs the row and column butterflies, one output
// row of transform coefficients per cycle into the queue while the queue accepts them.
// ----------------------------------------------------------------------------
module h4ftq_front
   import h4ftq_pkg::*;
#(
   parameter int SAMPLE_BITS = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_s [4],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [SAMPLE_BITS+5:0] out_y [4],
   output logic [1:0]                   out_row
);
   localparam int TB = SAMPLE_BITS + 3;   // after first pass
   localparam int YB = SAMPLE_BITS + 6;   // after second pass

   logic signed [SAMPLE_BITS-1:0] store_ff [4][4];
   logic signed [SAMPLE_BITS-1:0] store_in [4][4];
   logic [1:0] count_ff, count_in;
   logic       busy_ff, busy_in;
   logic [1:0] orow_ff, orow_in;
   logic signed [TB-1:0] t_row [4];
   logic signed [YB-1:0] y_row [4];
   logic signed [TB-1:0] a0, a1, a2, a3;
   logic signed [YB-1:0] b0, b1, b2, b3;

   assign in_ready  = !busy_ff;
   assign out_valid = busy_ff;
   assign out_row   = orow_ff;

   // column transform for the selected row of T
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         a0 = TB'(store_ff[0][c]); a1 = TB'(store_ff[1][c]);
         a2 = TB'(store_ff[2][c]); a3 = TB'(store_ff[3][c]);
         unique case (orow_ff)
            2'd0: t_row[c] = a0 + a1 + a2 + a3;
            2'd1: t_row[c] = (a0 <<< 1) + a1 - a2 - (a3 <<< 1);
            2'd2: t_row[c] = a0 - a1 - a2 + a3;
            default: t_row[c] = a0 - (a1 <<< 1) + (a2 <<< 1) - a3;
         endcase
      end
      b0 = YB'(t_row[0]); b1 = YB'(t_row[1]); b2 = YB'(t_row[2]); b3 = YB'(t_row[3]);
      y_row[0] = b0 + b1 + b2 + b3;
      y_row[1] = (b0 <<< 1) + b1 - b2 - (b3 <<< 1);
      y_row[2] = b0 - b1 - b2 + b3;
      y_row[3] = b0 - (b1 <<< 1) + (b2 <<< 1) - b3;
   end

   assign out_y = y_row;

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      orow_in  = orow_ff;
      if (in_valid && in_ready) begin
         store_in[count_ff] = in_s;
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd3) begin
            busy_in = 1'b1;
            orow_in = 2'd0;
         end
      end
      if (busy_ff && out_ready) begin
         orow_in = orow_ff + 2'd1;
         if (orow_ff == 2'd3) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      orow_ff  <= orow_in;
      if (reset) begin
         count_ff <= 2'd0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end
endmodule

// ===== rtl/h4ftq_queue.sv =====
// ----------------------------------------------------------------------------
// h4ftq_queue
// Two-entry queue between the transform front and the quantizer back.
// ----------------------------------------------------------------------------
module h4ftq_queue
   import h4ftq_pkg::*;
#(
   parameter int WIDTH = 62
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/h4ftq_back.sv =====
// ----------------------------------------------------------------------------
// h4ftq_back
// Quantizes one row of four coefficients: multiply stage, then round,
// shift and saturate into the output register.
// ----------------------------------------------------------------------------
module h4ftq_back
   import h4ftq_pkg::*;
#(
   parameter int SAMPLE_BITS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [QP_BITS-1:0]            qp,
   input  logic                          inter_rounding,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS+5:0] in_y [4],
   input  logic [1:0]                    in_row,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COEFF_BITS-1:0]  out_c [4],
   output logic [1:0]                    out_row
);
   localparam int YB = SAMPLE_BITS + 6;
   localparam int PB = YB + MF_BITS;

   logic [6:0]   split;
   logic [3:0]   per;
   logic [PB-1:0] prod_ff [4], prod_in [4];
   logic [3:0]   neg_ff;
   logic [1:0]   prow_ff;
   logic         pval_ff;
   logic         oval_ff;
   logic signed [COEFF_BITS-1:0] oc_ff [4];
   logic [1:0]   orow_ff;
   logic         padv, oadv;
   logic [PB:0]  off, sum;
   logic [PB:0]  lvl [4];
   logic [4:0]   qbits;
   logic [YB-1:0] mag [4];

   assign split = qp_split(qp);
   assign per   = split[6:3];
   assign qbits = 5'(QBITS_MIN) + 5'(per);

   assign oadv     = !oval_ff || out_ready;
   assign padv     = !pval_ff || oadv;
   assign in_ready = padv;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mag[c] = in_y[c][YB-1] ? YB'(-in_y[c]) : YB'(in_y[c]);
         prod_in[c] = PB'(mag[c]) * PB'(mf_lookup(split[2:0],
            (!in_row[0] && c % 2 == 0) ? 2'd0 :
            (in_row[0] && c % 2 == 1) ? 2'd1 : 2'd2));
      end
   end

   // offset = 2^qbits/3 or /6; 22'h2AAAAA is 2^23/3 rounded down
   always_comb begin
      off = inter_rounding ? ((PB+1)'(22'h2AAAAA) >> (24 - qbits))
                           : ((PB+1)'(22'h2AAAAA) >> (23 - qbits));
      for (int c = 0; c < 4; c++) begin
         sum    = (PB+1)'(prod_ff[c]) + off;
         lvl[c] = sum >> qbits;
      end
   end

   always_ff @(posedge clock) begin
      if (padv) begin
         prod_ff <= prod_in;
         for (int c = 0; c < 4; c++) neg_ff[c] <= in_y[c][YB-1];
         prow_ff <= in_row;
      end
      if (oadv) begin
         orow_ff <= prow_ff;
         for (int c = 0; c < 4; c++) begin
            if (neg_ff[c])
               oc_ff[c] <= (lvl[c] > (PB+1)'(4096)) ? -13'sd4096
                                                    : COEFF_BITS'(-lvl[c]);
            else
               oc_ff[c] <= (lvl[c] > (PB+1)'(4095)) ? 13'sd4095
                                                    : COEFF_BITS'(lvl[c]);
         end
      end
      if (reset) begin
         pval_ff <= 1'b0;
         oval_ff <= 1'b0;
      end else begin
         if (padv) pval_ff <= in_valid;
         if (oadv) oval_ff <= pval_ff;
      end
   end

   assign out_valid = oval_ff;
   assign out_c     = oc_ff;
   assign out_row   = orow_ff;
endmodule

// ===== rtl/h264_4x4_forward_transform_quant_unit.sv =====
// ----------------------------------------------------------------------------
// h264_4x4_forward_transform_quant_unit
// H.264 4x4 forward integer transform with quantization.
// ----------------------------------------------------------------------------
// A block enters as four rows of four samples, one row per transaction. After
// the fourth row the front unit emits one transformed row per cycle while the
// queue accepts them, with input held off until all four rows are out; a
// two-entry queue and the two-stage quantizer (multiply, then round and shift)
// follow. Output rows come out in order 0..3 with tlast on row 3.
module h264_4x4_forward_transform_quant_unit
   import h4ftq_pkg::*;
#(
   parameter int SAMPLE_BITS = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [QP_BITS-1:0]       csr_data,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample_0, sample_1, sample_2, sample_3 from bit 0 up, zero padded
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // coeff_0, coeff_1, coeff_2, coeff_3, out_row from bit 0 up, zero padded
   output logic [55:0]              rsp_tdata,
   output logic                     rsp_tlast
);
   localparam int YB = SAMPLE_BITS + 6;

   logic [QP_BITS-1:0] qp_ff;
   logic               inter_ff;
   logic signed [SAMPLE_BITS-1:0] s [4];
   logic signed [YB-1:0] fy [4], qy [4];
   logic [1:0]  frow, qrow, orow;
   logic        fval, frdy, qval, qrdy;
   logic [4*YB+1:0] qin, qout;
   logic signed [COEFF_BITS-1:0] c [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff    <= 6'd26;
         inter_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_QP:    qp_ff    <= csr_data;
            CSR_INTER: inter_ff <= csr_data[0];
            default:   ;
         endcase
      end
   end

   always_comb
      for (int i = 0; i < 4; i++) s[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];

   h4ftq_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_s(s),
      .out_valid(fval), .out_ready(frdy), .out_y(fy), .out_row(frow));

   assign qin = {frow, fy[3], fy[2], fy[1], fy[0]};

   h4ftq_queue #(.WIDTH(4*YB+2)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fval), .in_ready(frdy), .in_data(qin),
      .out_valid(qval), .out_ready(qrdy), .out_data(qout));

   always_comb begin
      for (int i = 0; i < 4; i++) qy[i] = qout[i*YB +: YB];
      qrow = qout[4*YB +: 2];
   end

   h4ftq_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .qp(qp_ff), .inter_rounding(inter_ff),
      .in_valid(qval), .in_ready(qrdy), .in_y(qy), .in_row(qrow),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_c(c), .out_row(orow));

   assign rsp_tdata = {2'b00, orow, c[3], c[2], c[1], c[0]};
   assign rsp_tlast = orow == 2'd3;
endmodule
